// ===== design/boed_pkg.sv =====
// shared constants and types of the box overlap enter/exit detector
// no dependencies; used by the interfaces, controller, datapath and checker
package boed_pkg;

	localparam int REQ_W   = 2;
	localparam int RAD_W   = 16;
	localparam int FIELD_W = 16;
	localparam int IDX_W   = 3;

	localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PROCESS = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic wr_a;
		logic wr_b;
		idx_t wr_idx;
		logic tok_vld;
		logic tok_end;
		idx_t pair_i;
		idx_t pair_j;
		logic ovf;
	} cmd_t;

	typedef struct packed {
		logic adv;
		logic done;
	} sts_t;

endpackage

// ===== design/boed_req_if.sv =====
// request channel of the detector: loads and process commands
// depends on boed_pkg
interface boed_req_if;
	logic                                valid;
	logic                                ready;
	logic        [boed_pkg::REQ_W-1:0]   req_type;
	logic        [boed_pkg::RAD_W-1:0]   radius;
	logic                                start_present;
	logic signed [boed_pkg::FIELD_W-1:0] start_x;
	logic signed [boed_pkg::FIELD_W-1:0] start_y;
	logic signed [boed_pkg::FIELD_W-1:0] start_z;
	logic                                end_present;
	logic signed [boed_pkg::FIELD_W-1:0] end_x;
	logic signed [boed_pkg::FIELD_W-1:0] end_y;
	logic signed [boed_pkg::FIELD_W-1:0] end_z;

	modport source (
		output valid, req_type, radius, start_present, start_x, start_y, start_z,
		output end_present, end_x, end_y, end_z,
		input  ready
	);
	modport sink (
		input  valid, req_type, radius, start_present, start_x, start_y, start_z,
		input  end_present, end_x, end_y, end_z,
		output ready
	);
endinterface

// ===== design/boed_evt_if.sv =====
// event channel of the detector: a single no-event beat if no pair gives one, else one beat per enter/exit event
// depends on boed_pkg
interface boed_evt_if;
	logic                       valid;
	logic                       ready;
	logic                       event_valid;
	logic                       exit_event;
	logic [boed_pkg::IDX_W-1:0] index_a;
	logic [boed_pkg::IDX_W-1:0] index_b;
	logic                       overflow;
	logic                       last;

	modport source (
		output valid, event_valid, exit_event, index_a, index_b, overflow, last,
		input  ready
	);
	modport sink (
		input  valid, event_valid, exit_event, index_a, index_b, overflow, last,
		output ready
	);
endinterface

// ===== design/boed_ctrl.sv =====
// controller: list fill counts, drop flag and the pair walker state machine
// depends on boed_pkg; drives the datapath through boed_pkg::cmd_t
module boed_ctrl #(
	parameter int LIST_DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [boed_pkg::REQ_W-1:0] req_type,
	output logic                       req_ready,
	output boed_pkg::cmd_t             cmd,
	input  boed_pkg::sts_t             sts
);

	localparam int CNTW = $clog2(LIST_DEPTH + 1);
	localparam int IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_END,
		ST_DRAIN
	} state_t;

	state_t          state_q;
	logic [CNTW-1:0] a_cnt_q;
	logic [CNTW-1:0] b_cnt_q;
	logic            drop_q;
	logic [IW-1:0]   i_q;
	logic [IW-1:0]   j_q;

	logic accept;
	logic empty;
	logic a_full;
	logic b_full;
	logic i_last;
	logic j_last;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign empty     = (a_cnt_q == '0) || (b_cnt_q == '0);
	assign a_full    = (a_cnt_q == CNTW'(LIST_DEPTH));
	assign b_full    = (b_cnt_q == CNTW'(LIST_DEPTH));
	assign i_last    = (CNTW'(i_q) == a_cnt_q - CNTW'(1));
	assign j_last    = (CNTW'(j_q) == b_cnt_q - CNTW'(1));

	always_comb begin
		cmd.wr_a    = accept && (req_type == boed_pkg::REQ_LOAD_A) && !a_full;
		cmd.wr_b    = accept && (req_type == boed_pkg::REQ_LOAD_B) && !b_full;
		cmd.wr_idx  = (req_type == boed_pkg::REQ_LOAD_A) ? boed_pkg::idx_t'(a_cnt_q)
			: boed_pkg::idx_t'(b_cnt_q);
		cmd.tok_vld = (state_q == ST_WALK) || (state_q == ST_END);
		cmd.tok_end = (state_q == ST_END) || ((state_q == ST_WALK) && empty);
		cmd.pair_i  = boed_pkg::idx_t'(i_q);
		cmd.pair_j  = boed_pkg::idx_t'(j_q);
		cmd.ovf     = drop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							boed_pkg::REQ_LOAD_A: begin
								if (a_full) drop_q <= 1'b1;
								else a_cnt_q <= a_cnt_q + CNTW'(1);
							end
							boed_pkg::REQ_LOAD_B: begin
								if (b_full) drop_q <= 1'b1;
								else b_cnt_q <= b_cnt_q + CNTW'(1);
							end
							boed_pkg::REQ_PROCESS: begin
								state_q <= ST_WALK;
								i_q     <= '0;
								j_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (sts.adv) begin
						if (empty) begin
							state_q <= ST_DRAIN;
						end else if (j_last) begin
							j_q <= '0;
							if (i_last) state_q <= ST_END;
							else i_q <= i_q + IW'(1);
						end else begin
							j_q <= j_q + IW'(1);
						end
					end
				end
				ST_END: begin
					if (sts.adv) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (sts.done) begin
						a_cnt_q <= '0;
						b_cnt_q <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/boed_dp.sv =====
// datapath: movement lists, three-stage pair test pipeline, held event and output register
// depends on boed_pkg and boed_evt_if; commanded by boed_ctrl
module boed_dp #(
	parameter int LIST_DEPTH  = 8,
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  boed_pkg::cmd_t                      cmd,
	output boed_pkg::sts_t                      sts,
	input  logic        [boed_pkg::RAD_W-1:0]   radius,
	input  logic                                start_present,
	input  logic signed [boed_pkg::FIELD_W-1:0] start_x,
	input  logic signed [boed_pkg::FIELD_W-1:0] start_y,
	input  logic signed [boed_pkg::FIELD_W-1:0] start_z,
	input  logic                                end_present,
	input  logic signed [boed_pkg::FIELD_W-1:0] end_x,
	input  logic signed [boed_pkg::FIELD_W-1:0] end_y,
	input  logic signed [boed_pkg::FIELD_W-1:0] end_z,
	boed_evt_if.source                          evt
);

	localparam int CW   = COORD_WIDTH;
	localparam int PW   = 1 + 3 * CW;
	localparam int IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int RSW  = boed_pkg::RAD_W + 1;
	localparam int CMPW = (CW + 2 > RSW + 1) ? CW + 2 : RSW + 1;

	// field bits above the coordinate width are ignored, sign taken from bit CW-1
	function automatic logic [CW-1:0] cvt(input logic [boed_pkg::FIELD_W-1:0] v);
		logic [31:0] ext;
		ext = {{(32 - boed_pkg::FIELD_W){1'b0}}, v};
		return ext[CW-1:0];
	endfunction

	function automatic logic [CW:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] d;
		d = {a[CW-1], a} - {b[CW-1], b};
		return d[CW] ? (~d + (CW+1)'(1)) : d;
	endfunction

	// list storage, no reset
	logic [boed_pkg::RAD_W-1:0] a_rad_q [LIST_DEPTH];
	logic [PW-1:0]              a_st_q  [LIST_DEPTH];
	logic [PW-1:0]              a_en_q  [LIST_DEPTH];
	logic [boed_pkg::RAD_W-1:0] b_rad_q [LIST_DEPTH];
	logic [PW-1:0]              b_st_q  [LIST_DEPTH];
	logic [PW-1:0]              b_en_q  [LIST_DEPTH];

	logic [PW-1:0] wr_st;
	logic [PW-1:0] wr_en;

	logic                       tok_vld_s1, tok_end_s1;
	logic [IW-1:0]              i_s1, j_s1;
	logic [boed_pkg::RAD_W-1:0] ar_s1, br_s1;
	logic [PW-1:0]              ast_s1, aen_s1, bst_s1, ben_s1;

	logic                       tok_vld_s2, tok_end_s2;
	logic [IW-1:0]              i_s2, j_s2;
	logic [RSW-1:0]             rsum_s2;
	logic                       st_pres_s2, en_pres_s2;
	logic [CW:0]                st_dx_s2, st_dy_s2, st_dz_s2;
	logic [CW:0]                en_dx_s2, en_dy_s2, en_dz_s2;

	logic                       pend_vld_q;
	logic                       pend_exit_q;
	logic [IW-1:0]              pend_i_q, pend_j_q;

	logic                       out_vld_q;
	logic                       out_ev_q, out_exit_q, out_ovf_q, out_last_q;
	logic [boed_pkg::IDX_W-1:0] out_ia_q, out_ib_q;

	logic            adv;
	logic [CMPW-1:0] rs;
	logic            st_in, en_in;
	logic            is_event, is_end;

	assign wr_st = {start_present, cvt(start_x), cvt(start_y), cvt(start_z)};
	assign wr_en = {end_present, cvt(end_x), cvt(end_y), cvt(end_z)};

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			a_rad_q[cmd.wr_idx[IW-1:0]] <= radius;
			a_st_q[cmd.wr_idx[IW-1:0]]  <= wr_st;
			a_en_q[cmd.wr_idx[IW-1:0]]  <= wr_en;
		end
		if (cmd.wr_b) begin
			b_rad_q[cmd.wr_idx[IW-1:0]] <= radius;
			b_st_q[cmd.wr_idx[IW-1:0]]  <= wr_st;
			b_en_q[cmd.wr_idx[IW-1:0]]  <= wr_en;
		end
	end

	assign adv = !out_vld_q || evt.ready;
	assign sts = '{adv: adv, done: adv && tok_vld_s2 && tok_end_s2};

	// stage 1: read the pair
	always_ff @(posedge clk) begin
		if (adv) begin
			tok_end_s1 <= cmd.tok_end;
			i_s1       <= cmd.pair_i[IW-1:0];
			j_s1       <= cmd.pair_j[IW-1:0];
			ar_s1      <= a_rad_q[cmd.pair_i[IW-1:0]];
			br_s1      <= b_rad_q[cmd.pair_j[IW-1:0]];
			ast_s1     <= a_st_q[cmd.pair_i[IW-1:0]];
			aen_s1     <= a_en_q[cmd.pair_i[IW-1:0]];
			bst_s1     <= b_st_q[cmd.pair_j[IW-1:0]];
			ben_s1     <= b_en_q[cmd.pair_j[IW-1:0]];
		end
	end

	// stage 2: radius sum and absolute distances
	always_ff @(posedge clk) begin
		if (adv) begin
			tok_end_s2 <= tok_end_s1;
			i_s2       <= i_s1;
			j_s2       <= j_s1;
			rsum_s2    <= RSW'(ar_s1) + RSW'(br_s1);
			st_pres_s2 <= ast_s1[PW-1] && bst_s1[PW-1];
			en_pres_s2 <= aen_s1[PW-1] && ben_s1[PW-1];
			st_dx_s2   <= abs_diff(ast_s1[3*CW-1:2*CW], bst_s1[3*CW-1:2*CW]);
			st_dy_s2   <= abs_diff(ast_s1[2*CW-1:CW], bst_s1[2*CW-1:CW]);
			st_dz_s2   <= abs_diff(ast_s1[CW-1:0], bst_s1[CW-1:0]);
			en_dx_s2   <= abs_diff(aen_s1[3*CW-1:2*CW], ben_s1[3*CW-1:2*CW]);
			en_dy_s2   <= abs_diff(aen_s1[2*CW-1:CW], ben_s1[2*CW-1:CW]);
			en_dz_s2   <= abs_diff(aen_s1[CW-1:0], ben_s1[CW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_s1 <= 1'b0;
			tok_vld_s2 <= 1'b0;
		end else if (adv) begin
			tok_vld_s1 <= cmd.tok_vld;
			tok_vld_s2 <= tok_vld_s1;
		end
	end

	// stage 3: inside tests, event selection
	always_comb begin
		rs       = CMPW'(rsum_s2);
		st_in    = st_pres_s2 && (CMPW'(st_dx_s2) < rs) && (CMPW'(st_dy_s2) < rs)
			&& (CMPW'({st_dz_s2, 1'b0}) < rs);
		en_in    = en_pres_s2 && (CMPW'(en_dx_s2) < rs) && (CMPW'(en_dy_s2) < rs)
			&& (CMPW'({en_dz_s2, 1'b0}) < rs);
		is_event = tok_vld_s2 && !tok_end_s2 && (st_in != en_in);
		is_end   = tok_vld_s2 && tok_end_s2;
	end

	// an event is held until the next event or the end token shows whether it is the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b0;
			if (is_event) begin
				pend_vld_q <= 1'b1;
				if (pend_vld_q) out_vld_q <= 1'b1;
			end else if (is_end) begin
				pend_vld_q <= 1'b0;
				out_vld_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (is_event) begin
				pend_exit_q <= st_in;
				pend_i_q    <= i_s2;
				pend_j_q    <= j_s2;
			end
			if (is_event || is_end) begin
				out_ev_q   <= pend_vld_q;
				out_exit_q <= pend_vld_q && pend_exit_q;
				out_ia_q   <= pend_vld_q ? boed_pkg::idx_t'(pend_i_q) : '0;
				out_ib_q   <= pend_vld_q ? boed_pkg::idx_t'(pend_j_q) : '0;
				out_ovf_q  <= cmd.ovf;
				out_last_q <= is_end;
			end
		end
	end

	assign evt.valid       = out_vld_q;
	assign evt.event_valid = out_ev_q;
	assign evt.exit_event  = out_exit_q;
	assign evt.index_a     = out_ia_q;
	assign evt.index_b     = out_ib_q;
	assign evt.overflow    = out_ovf_q;
	assign evt.last        = out_last_q;

endmodule

// ===== design/box_overlap_enter_exit_detector.sv =====
// Box overlap enter/exit detector, top level.
//
// Channels: req (boed_req_if sink) takes load and process beats, evt
// (boed_evt_if source) gives event beats. A beat moves when valid and ready
// are both high at a rising edge of clk.
// A load beat (group A or B) gives no event; a load
// into a full list is dropped and raises overflow on the next process.
// A process beat walks every stored A-B pair, one pair per cycle unless evt
// stalls, through a three-stage test pipeline, and gives one beat per pair
// whose start and end inside states differ, or a single beat with event_valid
// low; last marks the final beat. Each event is held until the next event or
// the end of the walk shows whether it is the last.
// req.ready is low from a process beat until its last event beat is loaded
// into the output register; loads are taken one per cycle otherwise, also
// while an event beat still waits at evt.
// A stall on evt freezes the whole pair pipeline and the walker.
// Reset (arst_n low) empties both lists, clears the drop flag and the output.
// Depends on boed_pkg, boed_req_if, boed_evt_if, boed_ctrl and boed_dp.
module box_overlap_enter_exit_detector #(
	parameter int LIST_DEPTH  = 8,
	parameter int COORD_WIDTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	boed_req_if.sink req,
	boed_evt_if.source evt
);

	boed_pkg::cmd_t cmd;
	boed_pkg::sts_t sts;
	logic           ready;

	assign req.ready = ready;

	boed_ctrl #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	boed_dp #(
		.LIST_DEPTH  (LIST_DEPTH),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.radius        (req.radius),
		.start_present (req.start_present),
		.start_x       (req.start_x),
		.start_y       (req.start_y),
		.start_z       (req.start_z),
		.end_present   (req.end_present),
		.end_x         (req.end_x),
		.end_y         (req.end_y),
		.end_z         (req.end_z),
		.evt           (evt)
	);

endmodule

// ===== design/boed_chk.sv =====
// port-level checker for the detector and its bind to the top level
// depends on boed_pkg and box_overlap_enter_exit_detector
module boed_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic [boed_pkg::REQ_W-1:0] req_type,
	input logic                       evt_valid,
	input logic                       evt_ready,
	input logic                       event_valid,
	input logic                       exit_event,
	input logic [boed_pkg::IDX_W-1:0] index_a,
	input logic [boed_pkg::IDX_W-1:0] index_b,
	input logic                       last
);

	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid)
		else $error("event beat dropped while stalled");

	a_evt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> $stable(last) && $stable(index_a) && $stable(index_b))
		else $error("event beat changed while stalled");

	a_proc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == boed_pkg::REQ_PROCESS) |=> !req_ready)
		else $error("request taken during a process walk");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !event_valid |-> last && !exit_event && (index_a == '0)
			&& (index_b == '0))
		else $error("no-event beat malformed");

	a_one_per_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && !last |-> !req_ready)
		else $error("request channel open before the last event beat");

endmodule

bind box_overlap_enter_exit_detector boed_chk u_boed_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_type    (req.req_type),
	.evt_valid   (evt.valid),
	.evt_ready   (evt.ready),
	.event_valid (evt.event_valid),
	.exit_event  (evt.exit_event),
	.index_a     (evt.index_a),
	.index_b     (evt.index_b),
	.last        (evt.last)
);
